/* rtl/depq_pkg.sv */
// Shared types, codes and constants for the double-ended priority queue.
package depq_pkg;

    // Default number of storage cells per chain
    localparam int DEPQ_CAPACITY = 64;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_NOP     = 2'd3
    } depq_op_t;

    // Per-cycle command broadcast to every cell of a chain
    typedef struct packed {
        logic ins;    // insert key at its sorted place
        logic shift;  // every cell but the last takes its upper neighbor's value; the last cell holds
    } depq_ctrl_t;

endpackage

/* rtl/depq_cell.sv */
// One compare-and-shift cell of a sorted chain.
module depq_cell #(
    parameter bit DESCEND = 1'b0
) (
    input  logic                              clk,
    input  depq_pkg::depq_ctrl_t              ctrl,
    input  logic signed [depq_pkg::VALUE_W-1:0] key,
    input  logic                              occupied,
    input  logic signed [depq_pkg::VALUE_W-1:0] lower_value,
    input  logic                              lower_after,
    input  logic signed [depq_pkg::VALUE_W-1:0] upper_value,
    output logic signed [depq_pkg::VALUE_W-1:0] value,
    output logic                              after
);
    import depq_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // key sorts ahead of this cell's entry
    always_comb
    begin
        if (DESCEND)
            after = occupied && (value_reg < key);
        else
            after = occupied && (value_reg > key);
    end

    // insert: take the lower neighbor's entry, the key, or hold; shift: take the upper neighbor's entry
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (lower_after)
                value_next = lower_value;
            else if (after || !occupied)
                value_next = key;
        end
        else if (ctrl.shift)
        begin
            value_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* rtl/depq_chain.sv */
// Row of sorted cells; cell 0 holds the front entry of the order.
module depq_chain #(
    parameter int CAPACITY = depq_pkg::DEPQ_CAPACITY,
    parameter bit DESCEND  = 1'b0,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  depq_pkg::depq_ctrl_t              ctrl,
    input  logic signed [depq_pkg::VALUE_W-1:0] key,
    input  logic [CW-1:0]                     count,
    output logic signed [depq_pkg::VALUE_W-1:0] front
);
    import depq_pkg::*;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_after [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [VALUE_W-1:0] lower_value;
            logic                      lower_after;
            logic signed [VALUE_W-1:0] upper_value;
            logic                      occupied;

            // neighbor taps; cell 0 sees the key below it, the last cell sees its own value above it
            if (i == 0)
            begin : g_first
                assign lower_value = key;
                assign lower_after = 1'b0;
            end
            else
            begin : g_mid
                assign lower_value = cell_value[i-1];
                assign lower_after = cell_after[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign upper_value = cell_value[i];
            end
            else
            begin : g_up
                assign upper_value = cell_value[i+1];
            end

            assign occupied = (CW'(i) < count);

            depq_cell #(
                .DESCEND (DESCEND)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (key),
                .occupied    (occupied),
                .lower_value (lower_value),
                .lower_after (lower_after),
                .upper_value (upper_value),
                .value       (cell_value[i]),
                .after       (cell_after[i])
            );
        end
    endgenerate

    assign front = cell_value[0];

endmodule

/* rtl/double_ended_priority_queue.sv */
// Top level: bounded double-ended priority queue built from two sorted cell chains.
//
//  channel   direction  handshake           fields
//  command   in         start & !busy       opcode, value
//  result    out        done (one cycle)    max_value, min_value, is_empty,
//                                           entry_count, dropped
//
// One word per cycle: an insert updates both chains and a delete one chain at the
// clock edge that accepts it, and its result is on the ports during the following cycle.
// busy stays low; the insert compare in every cell sets the cycle time.
// rst_n clears the count, the strobe and the drop flag; cell contents are don't-care until
// written. The receiver cannot stall, so each result shows for one cycle only.
module double_ended_priority_queue #(
    parameter int CAPACITY = depq_pkg::DEPQ_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic signed [depq_pkg::VALUE_W-1:0] value,
    output logic                                done,
    output logic signed [depq_pkg::VALUE_W-1:0] max_value,
    output logic signed [depq_pkg::VALUE_W-1:0] min_value,
    output logic                                is_empty,
    output logic [depq_pkg::COUNT_W-1:0]        entry_count,
    output logic                                dropped
);
    import depq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]        count_reg, count_next;
    logic                 done_reg, done_next;
    logic                 dropped_reg, dropped_next;
    depq_ctrl_t           asc_ctrl, desc_ctrl;
    logic signed [VALUE_W-1:0] asc_front, desc_front;
    logic                 accept;
    logic                 full;
    logic                 empty_now;
    depq_op_t             op;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign op        = depq_op_t'(opcode);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty_now = (count_reg == '0);

    // decode the command into chain controls, the new count and the drop flag
    always_comb
    begin
        asc_ctrl     = '0;
        desc_ctrl    = '0;
        count_next   = count_reg;
        dropped_next = 1'b0;
        if (accept)
        begin
            unique case (op)
                OP_INSERT:
                begin
                    if (full)
                        dropped_next = 1'b1;
                    else
                    begin
                        asc_ctrl.ins  = 1'b1;
                        desc_ctrl.ins = 1'b1;
                        count_next    = count_reg + CW'(1);
                    end
                end
                OP_DEL_MAX:
                begin
                    if (!empty_now)
                    begin
                        desc_ctrl.shift = 1'b1;
                        count_next      = count_reg - CW'(1);
                    end
                end
                OP_DEL_MIN:
                begin
                    if (!empty_now)
                    begin
                        asc_ctrl.shift = 1'b1;
                        count_next     = count_reg - CW'(1);
                    end
                end
                OP_NOP:
                begin
                    count_next = count_reg;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign done_next = accept;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            done_reg    <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            done_reg    <= done_next;
            dropped_reg <= dropped_next;
        end
    end

    // ascending chain: cell 0 is the smallest entry
    depq_chain #(
        .CAPACITY (CAPACITY),
        .DESCEND  (1'b0),
        .CW       (CW)
    ) u_asc (
        .clk   (clk),
        .ctrl  (asc_ctrl),
        .key   (value),
        .count (count_reg),
        .front (asc_front)
    );

    // descending chain: cell 0 is the largest entry
    depq_chain #(
        .CAPACITY (CAPACITY),
        .DESCEND  (1'b1),
        .CW       (CW)
    ) u_desc (
        .clk   (clk),
        .ctrl  (desc_ctrl),
        .key   (value),
        .count (count_reg),
        .front (desc_front)
    );

    // result word, read from the updated chains
    assign done        = done_reg;
    assign is_empty    = empty_now;
    assign max_value   = empty_now ? '0 : desc_front;
    assign min_value   = empty_now ? '0 : asc_front;
    assign entry_count = COUNT_W'(count_reg);
    assign dropped     = dropped_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("no result word after an accepted command");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped |-> (done && count_reg == CW'(CAPACITY) && $stable(count_reg)))
        else $error("drop flagged while room remained");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        !is_empty |-> (min_value <= max_value))
        else $error("smallest entry above largest entry");
`endif

endmodule
